[hw/rtl/cpi_pkg.sv]
// Shared types and constants for the colour palette interning block.
package cpi_pkg;

  localparam int unsigned COLOR_W       = 32;
  localparam int unsigned IDX_OUT_W     = 8;
  localparam int unsigned CNT_OUT_W     = 9;
  localparam int unsigned MOD_STEP_BITS = 4;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] palette_index;
    logic                 was_present;
    logic                 full_res;
    logic [CNT_OUT_W-1:0] entries_used;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_WALK,
    ST_APPEND,
    ST_LINK,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic latch_in;
    logic head_rd;
    logic ent_rd_head;
    logic walk_step;
    logic ent_rd_link;
    logic set_found;
    logic set_full;
    logic append;
    logic link;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_busy;
    logic head_valid;
    logic ent_match;
    logic link_valid;
    logic have_tail;
    logic is_full;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/cpi_stream_if.sv]
// Valid/ready stream interface carrying one beat of a given payload type.
interface cpi_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/cpi_ram.sv]
// Generic single write port, single read port RAM with registered read.
module cpi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/cpi_mod.sv]
// Iterative remainder unit: colour modulo the bucket count, a nibble per cycle.
module cpi_mod #(
  parameter int unsigned MODULUS = 1711
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [cpi_pkg::COLOR_W-1:0]                value_i,
  output logic                                       busy_o,
  output logic [(MODULUS > 1 ? $clog2(MODULUS) : 1)-1:0] rem_o
);

  localparam int unsigned REM_W = (MODULUS > 1) ? $clog2(MODULUS) : 1;
  localparam int unsigned STEPS = cpi_pkg::COLOR_W / cpi_pkg::MOD_STEP_BITS;
  localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [cpi_pkg::COLOR_W-1:0] val_q;
  logic [REM_W-1:0]            rem_q, rem_d;
  logic [STEP_W-1:0]           step_q;
  logic                        busy_q;

  // shift-and-subtract: remainder stays below MODULUS after each bit
  always_comb begin
    logic [REM_W:0] t;
    rem_d = rem_q;
    t     = '0;
    for (int i = 0; i < int'(cpi_pkg::MOD_STEP_BITS); i++) begin
      t = {rem_d, val_q[cpi_pkg::COLOR_W-1-i]};
      if (t >= (REM_W+1)'(MODULUS)) begin
        t = t - (REM_W+1)'(MODULUS);
      end
      rem_d = t[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      rem_q <= '0;
    end else if (busy_q) begin
      val_q <= val_q << cpi_pkg::MOD_STEP_BITS;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/cpi_datapath.sv]
// Datapath: hash unit, bucket head and entry memories, walk registers, result beat.
module cpi_datapath #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned HASH_BUCKETS  = 1711
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cpi_pkg::cmd_t               cmd_i,
  output cpi_pkg::status_t            status_o,
  input  logic [cpi_pkg::COLOR_W-1:0] in_color_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output cpi_pkg::out_beat_t          out_data_o
);

  localparam int unsigned IDX_W  = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned BKT_W  = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
  localparam int unsigned HEAD_W = IDX_W + 1;
  localparam int unsigned ENT_W  = cpi_pkg::COLOR_W + 1 + IDX_W;

  logic [cpi_pkg::COLOR_W-1:0] color_q;
  logic [cpi_pkg::COLOR_W-1:0] tail_color_q;
  logic [IDX_W-1:0]            cur_q, tail_q, res_idx_q;
  logic                        have_tail_q;
  logic [CNT_W-1:0]            count_q;
  logic [BKT_W-1:0]            clr_q;
  logic                        res_present_q, res_full_q;
  logic                        out_valid_q;
  cpi_pkg::out_beat_t          out_data_q;

  logic [BKT_W-1:0]  bucket;
  logic              mod_busy;
  logic [IDX_W-1:0]  fresh;

  logic              head_we, head_re;
  logic [BKT_W-1:0]  head_waddr;
  logic [HEAD_W-1:0] head_wdata, head_rdata;

  logic              ent_we, ent_re;
  logic [IDX_W-1:0]  ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;

  logic [cpi_pkg::COLOR_W-1:0] ent_color;
  logic                        ent_link_valid;
  logic [IDX_W-1:0]            ent_link;
  logic [IDX_W-1:0]            head_idx;

  logic [IDX_W+cpi_pkg::IDX_OUT_W-1:0] idx_ext;
  logic [CNT_W+cpi_pkg::CNT_OUT_W-1:0] cnt_ext;

  cpi_mod #(
    .MODULUS (HASH_BUCKETS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.latch_in),
    .value_i (in_color_i),
    .busy_o  (mod_busy),
    .rem_o   (bucket)
  );

  assign fresh = count_q[IDX_W-1:0];

  // head word: {valid, first index}; swept to zero after reset
  assign head_we    = cmd_i.clr_wr | (cmd_i.append & ~have_tail_q);
  assign head_waddr = cmd_i.clr_wr ? clr_q : bucket;
  assign head_wdata = cmd_i.clr_wr ? '0 : {1'b1, fresh};
  assign head_re    = cmd_i.head_rd;
  assign head_idx   = head_rdata[IDX_W-1:0];

  cpi_ram #(
    .WIDTH (HEAD_W),
    .DEPTH (HASH_BUCKETS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (bucket),
    .rdata_o (head_rdata)
  );

  // entry word: {colour, link valid, link}; a new entry is written with its
  // link invalid, so the link store needs no clearing
  assign ent_we    = cmd_i.append | cmd_i.link;
  assign ent_waddr = cmd_i.append ? fresh : tail_q;
  assign ent_wdata = cmd_i.append ? {color_q, 1'b0, {IDX_W{1'b0}}}
                                  : {tail_color_q, 1'b1, res_idx_q};
  assign ent_re    = cmd_i.ent_rd_head | cmd_i.ent_rd_link;
  assign ent_raddr = cmd_i.ent_rd_head ? head_idx : ent_link;

  cpi_ram #(
    .WIDTH (ENT_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  assign ent_color      = ent_rdata[ENT_W-1 -: cpi_pkg::COLOR_W];
  assign ent_link_valid = ent_rdata[IDX_W];
  assign ent_link       = ent_rdata[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_tail_q <= 1'b0;
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + BKT_W'(1);
      end
      if (cmd_i.latch_in) begin
        have_tail_q <= 1'b0;
      end else if (cmd_i.walk_step) begin
        have_tail_q <= 1'b1;
      end
      if (cmd_i.append) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign idx_ext = {{cpi_pkg::IDX_OUT_W{1'b0}}, res_idx_q};
  assign cnt_ext = {{cpi_pkg::CNT_OUT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      color_q <= in_color_i;
    end
    if (cmd_i.ent_rd_head) begin
      cur_q <= head_idx;
    end else if (cmd_i.ent_rd_link) begin
      cur_q <= ent_link;
    end
    if (cmd_i.walk_step) begin
      tail_q       <= cur_q;
      tail_color_q <= ent_color;
    end
    if (cmd_i.set_found) begin
      res_idx_q     <= cur_q;
      res_present_q <= 1'b1;
      res_full_q    <= 1'b0;
    end else if (cmd_i.set_full) begin
      res_idx_q     <= '0;
      res_present_q <= 1'b0;
      res_full_q    <= 1'b1;
    end else if (cmd_i.append) begin
      res_idx_q     <= fresh;
      res_present_q <= 1'b0;
      res_full_q    <= 1'b0;
    end
    if (cmd_i.load_out) begin
      out_data_q.palette_index <= idx_ext[cpi_pkg::IDX_OUT_W-1:0];
      out_data_q.was_present   <= res_present_q;
      out_data_q.full_res      <= res_full_q;
      out_data_q.entries_used  <= cnt_ext[cpi_pkg::CNT_OUT_W-1:0];
    end
  end

  assign status_o.clr_last   = (clr_q == BKT_W'(HASH_BUCKETS - 1));
  assign status_o.mod_busy   = mod_busy;
  assign status_o.head_valid = head_rdata[IDX_W];
  assign status_o.ent_match  = (ent_color == color_q);
  assign status_o.link_valid = ent_link_valid;
  assign status_o.have_tail  = have_tail_q;
  assign status_o.is_full    = (count_q >= CNT_W'(PALETTE_DEPTH));
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hw/rtl/cpi_ctrl.sv]
// Controller: sequences the clearing sweep, hashing, chain walk, append and result load.
module cpi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cpi_pkg::status_t status_i,
  output cpi_pkg::cmd_t    cmd_o
);

  cpi_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpi_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cpi_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = cpi_pkg::ST_IDLE;
        end
      end
      cpi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = cpi_pkg::ST_MOD;
        end
      end
      cpi_pkg::ST_MOD: begin
        if (!status_i.mod_busy) begin
          state_d = cpi_pkg::ST_HEAD_RD;
        end
      end
      cpi_pkg::ST_HEAD_RD: begin
        cmd_o.head_rd = 1'b1;
        state_d       = cpi_pkg::ST_HEAD_CHK;
      end
      cpi_pkg::ST_HEAD_CHK: begin
        if (status_i.head_valid) begin
          cmd_o.ent_rd_head = 1'b1;
          state_d           = cpi_pkg::ST_WALK;
        end else if (status_i.is_full) begin
          cmd_o.set_full = 1'b1;
          state_d        = cpi_pkg::ST_RESULT;
        end else begin
          state_d = cpi_pkg::ST_APPEND;
        end
      end
      cpi_pkg::ST_WALK: begin
        if (status_i.ent_match) begin
          cmd_o.set_found = 1'b1;
          state_d         = cpi_pkg::ST_RESULT;
        end else begin
          cmd_o.walk_step = 1'b1;
          if (status_i.link_valid) begin
            cmd_o.ent_rd_link = 1'b1;
          end else if (status_i.is_full) begin
            cmd_o.set_full = 1'b1;
            state_d        = cpi_pkg::ST_RESULT;
          end else begin
            state_d = cpi_pkg::ST_APPEND;
          end
        end
      end
      cpi_pkg::ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = status_i.have_tail ? cpi_pkg::ST_LINK : cpi_pkg::ST_RESULT;
      end
      cpi_pkg::ST_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = cpi_pkg::ST_RESULT;
      end
      cpi_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = cpi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/color_palette_intern.sv]
// Top level of the colour palette interning block.
//
// Each input beat carries a 32-bit RGBA colour; one result beat comes back with
// its palette index, a present flag, a full flag and the entry count. The bucket
// is colour modulo HASH_BUCKETS, worked out by a remainder unit four bits per
// cycle; the bucket head is then read and the chain walked through the entry
// memory at one stored entry per cycle. A new colour is written in an append
// step, with a further link step when it goes behind a chain tail, and the
// result is then loaded into the output register. The load waits while the
// previous result still sits unaccepted in the output register. One item is in
// flight at a time; a finished result waits in the output register while the
// next colour is taken. After reset the bucket head memory is swept clear, and
// no input is accepted during the sweep.
module color_palette_intern #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned HASH_BUCKETS  = 1711
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cpi_stream_if.sink   in_i,
  cpi_stream_if.source out_o
);

  cpi_pkg::cmd_t    cmd;
  cpi_pkg::status_t status;
  logic             in_ready;

  cpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cpi_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .HASH_BUCKETS  (HASH_BUCKETS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_color_i  (in_i.data.color),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

endmodule

[test/tb_color_palette_intern.sv]
// Self-checking testbench for the colour palette interning block.
module tb_color_palette_intern;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned HASH_BUCKETS  = 1711;
  localparam int unsigned ITEM_TARGET   = 650;
  localparam int unsigned MAX_KEY_MULT  = 2510000;  // keeps bucket + 1711*k below 2^32

  logic clk = 1'b0;
  logic rst_n;
  bit   no_gaps = 1'b0;

  always #6 clk = ~clk;

  cpi_stream_if #(.payload_t(cpi_pkg::in_beat_t))  color_if ();
  cpi_stream_if #(.payload_t(cpi_pkg::out_beat_t)) result_if ();

  color_palette_intern #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .HASH_BUCKETS (HASH_BUCKETS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (color_if),
    .out_o (result_if)
  );

  // Predicted palette state
  bit [7:0]  head_slot  [HASH_BUCKETS];
  bit        head_live  [HASH_BUCKETS];
  bit [7:0]  next_slot  [PALETTE_DEPTH];
  bit        next_live  [PALETTE_DEPTH];
  bit [31:0] slot_color [PALETTE_DEPTH];
  bit [8:0]  colors_used;

  cpi_pkg::out_beat_t pending_lookups[$];
  logic [31:0]        known_colors[$];

  int unsigned n_sent, n_checked, n_hits, n_rejected, n_errors, longest_chain;

  function automatic cpi_pkg::out_beat_t intern_color(input logic [31:0] c);
    int unsigned        bucket;
    int unsigned        cur, tail, steps;
    bit                 more, have_tail;
    cpi_pkg::out_beat_t r;
    bucket    = c % HASH_BUCKETS;
    more      = head_live[bucket];
    cur       = head_slot[bucket];
    tail      = 0;
    have_tail = 1'b0;
    steps     = 0;
    r         = '0;
    while (more && steps < PALETTE_DEPTH && !r.was_present) begin
      if (slot_color[cur] == c) begin
        r.was_present   = 1'b1;
        r.palette_index = cur[7:0];
      end else begin
        tail      = cur;
        have_tail = 1'b1;
        more      = next_live[cur];
        cur       = next_slot[cur];
        steps++;
      end
    end
    if (steps > longest_chain) longest_chain = steps;
    if (!r.was_present) begin
      if (colors_used >= PALETTE_DEPTH) begin
        r.full_res = 1'b1;
      end else begin
        if (have_tail) begin
          next_slot[tail] = colors_used[7:0];
          next_live[tail] = 1'b1;
        end else begin
          head_slot[bucket] = colors_used[7:0];
          head_live[bucket] = 1'b1;
        end
        slot_color[colors_used[7:0]] = c;
        r.palette_index = colors_used[7:0];
        colors_used++;
      end
    end
    r.entries_used = colors_used;
    return r;
  endfunction

  function automatic logic [31:0] color_in_bucket(input int unsigned bucket);
    longint unsigned v;
    v = longint'(bucket) + longint'(HASH_BUCKETS) * longint'($urandom_range(MAX_KEY_MULT));
    return v[31:0];
  endfunction

  function automatic logic [31:0] pick_known();
    return known_colors[$urandom_range(known_colors.size() - 1)];
  endfunction

  // Holds valid across back-to-back beats; only drops it during a gap.
  task automatic send_color(input logic [31:0] c);
    if (!no_gaps) begin
      while ($urandom_range(99) < 33) begin
        color_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    color_if.valid      <= 1'b1;
    color_if.data.color <= c;
    @(posedge clk);
    while (!color_if.ready) @(posedge clk);
    pending_lookups.push_back(intern_color(c));
    known_colors.push_back(c);
    n_sent++;
  endtask

  always @(posedge clk) begin
    result_if.ready <= no_gaps || ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    cpi_pkg::out_beat_t want, got;
    if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      got = result_if.data;
      if (pending_lookups.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: unexpected result beat idx=%0d present=%0b full=%0b used=%0d",
                   $realtime, got.palette_index, got.was_present, got.full_res,
                   got.entries_used);
      end else begin
        want = pending_lookups.pop_front();
        n_checked++;
        if (want.was_present) n_hits++;
        if (want.full_res) n_rejected++;
        if (got.palette_index !== want.palette_index || got.was_present !== want.was_present
            || got.full_res !== want.full_res || got.entries_used !== want.entries_used) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("%0t: mismatch exp idx=%0d present=%0b full=%0b used=%0d",
                     $realtime, want.palette_index, want.was_present, want.full_res,
                     want.entries_used);
            $display("%0t:          got idx=%0d present=%0b full=%0b used=%0d",
                     $realtime, got.palette_index, got.was_present, got.full_res,
                     got.entries_used);
          end
        end
      end
    end
  end

  // Extremes, head hits, chains in bucket zero and the last bucket, repeats
  task automatic test_directed();
    logic [31:0] seq[$];
    seq = '{32'h0000_0000, 32'hFFFF_FFFF, 32'd1711, 32'd3422, 32'h0000_0000, 32'd3422,
            32'd1711, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
            32'h5555_5555, 32'd1710, 32'd3421, 32'hFFFF_FFFF - 32'd1711, 32'h0000_0001,
            32'hAAAA_AAAA, 32'h5555_5555, 32'd3421, 32'hFFFF_FFFF - 32'd1711};
    foreach (seq[i]) send_color(seq[i]);
  endtask

  // Deep chains in a few buckets; run without any gaps on either side
  task automatic test_chain_collisions();
    int unsigned buckets[4];
    no_gaps = 1'b1;
    foreach (buckets[i]) buckets[i] = $urandom_range(HASH_BUCKETS - 1);
    repeat (150) begin
      if ($urandom_range(99) < 35) send_color(pick_known());
      else send_color(color_in_bucket(buckets[$urandom_range(3)]));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_fill_palette();
    int unsigned guard;
    guard = 0;
    while (colors_used < PALETTE_DEPTH && guard < 600) begin
      case ($urandom_range(9))
        0, 1, 2: send_color(pick_known());
        3, 4:    send_color(color_in_bucket(pick_known() % HASH_BUCKETS));
        default: send_color($urandom());
      endcase
      guard++;
    end
  endtask

  // Palette full: new colours are turned away, stored ones still hit
  task automatic test_palette_full();
    int unsigned k;
    k = 0;
    while (k < 150 || n_sent < ITEM_TARGET) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_color(pick_known());
        4:          send_color(($urandom_range(1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF);
        default:    send_color($urandom());
      endcase
      k++;
    end
  endtask

  initial begin
    int unsigned wait_cycles;
    rst_n = 1'b0;
    color_if.valid  <= 1'b0;
    color_if.data   <= '0;
    colors_used = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_chain_collisions();
    test_fill_palette();
    test_palette_full();
    color_if.valid <= 1'b0;

    wait_cycles = 0;
    while (pending_lookups.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (300) @(posedge clk);

    $display("Interned %0d colours, %0d results checked: %0d hits, %0d turned away when full",
             n_sent, n_checked, n_hits, n_rejected);
    $display("Palette reached %0d entries, longest chain walked %0d, %0d mismatches",
             colors_used, longest_chain, n_errors);
    if (n_errors == 0 && pending_lookups.size() == 0) begin
      $display("PASS color_palette_intern");
    end else begin
      $display("FAIL color_palette_intern");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL color_palette_intern");
    $finish;
  end

endmodule

[color_palette_intern.f]
hw/rtl/cpi_pkg.sv
hw/rtl/cpi_stream_if.sv
hw/rtl/cpi_ram.sv
hw/rtl/cpi_mod.sv
hw/rtl/cpi_datapath.sv
hw/rtl/cpi_ctrl.sv
hw/rtl/color_palette_intern.sv
test/tb_color_palette_intern.sv
